[rtl/core/sequential_list_engine_top_assert.svh]
// Assertion macros shared by the checkers of the sequential list engine.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequential list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequential list engine check failed");

`endif

[rtl/core/sle_pkg.sv]
// Types and constants of the sequential list engine.
package sle_pkg;

	localparam int OP_W  = 3;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OP_W-1:0] OP_GET    = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Bit layout of the input tdata.
	localparam int IN_POS_LSB = 0;
	localparam int IN_VAL_LSB = IN_POS_LSB + POS_W;
	localparam int IN_DATA_W  = 40;

	// Bit layout of the output tdata.
	localparam int OUT_ST_LSB  = 0;
	localparam int OUT_RV_LSB  = OUT_ST_LSB + ST_W;
	localparam int OUT_FD_BIT  = OUT_RV_LSB + VAL_W;
	localparam int OUT_CNT_LSB = OUT_FD_BIT + 1;
	localparam int OUT_HAS_BIT = OUT_CNT_LSB + CNT_W;
	localparam int OUT_DATA_W  = 48;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] read_value;
		logic                    found;
	} res_t;

endpackage

[rtl/core/sle_mem.sv]
// Element store: one write port and one read port with registered read data.
module sle_mem
	import sle_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [VAL_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [VAL_W-1:0] rdata
);

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/sle_seq.sv]
// Operation sequencer: decodes an item, walks the store and keeps the element count.
module sle_seq
	import sle_pkg::*;
#(
	parameter int CAPACITY = 64,
	parameter int AW       = 6,
	parameter int CW       = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  in_op,
	input  logic [POS_W-1:0] in_pos,
	input  logic [VAL_W-1:0] in_val,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	output logic [CW-1:0]    count,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [VAL_W-1:0] mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  logic [VAL_W-1:0] mem_rdata
);

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_DONE} state_t;

	state_t           state_q;
	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    ptr_q;
	logic             pend_s1;
	logic [AW-1:0]    raddr_s1;
	res_t             res_q;

	logic [CMPW-1:0] pos_w;
	logic [CMPW-1:0] cnt_w;
	logic [CMPW-1:0] pos_m1;
	logic            pos_ok;
	logic            full;
	logic            accept;
	logic            issue;
	logic            hit;

	always_comb begin
		pos_w  = CMPW'(in_pos);
		cnt_w  = CMPW'(count_q);
		pos_m1 = pos_w - CMPW'(1);
		pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
		full   = (count_q == CW'(CAPACITY));
		accept = (state_q == S_IDLE) && in_valid;
		issue  = (state_q == S_SCAN) && (ptr_q < count_q);
		hit    = (state_q == S_SCAN) && pend_s1 && (op_q == OP_SEARCH) && (mem_rdata == val_q);
	end

	// Store ports. During a delete the write goes two entries below the read,
	// so the same entry is never read and written in one cycle.
	always_comb begin
		if (state_q == S_IDLE) begin
			mem_we    = accept && (in_op == OP_APPEND) && !full;
			mem_waddr = count_q[AW-1:0];
			mem_wdata = in_val;
			mem_re    = accept && (in_op == OP_GET) && pos_ok;
			mem_raddr = pos_m1[AW-1:0];
		end else begin
			mem_we    = (state_q == S_SCAN) && pend_s1 && (op_q == OP_DELETE);
			mem_waddr = raddr_s1 - AW'(1);
			mem_wdata = mem_rdata;
			mem_re    = issue;
			mem_raddr = ptr_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_CLEAR;
			val_q    <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
			pend_s1  <= 1'b0;
			raddr_s1 <= '0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= in_op;
						val_q   <= in_val;
						pend_s1 <= 1'b0;
						res_q   <= '0;
						unique case (in_op)
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= S_DONE;
							end
							OP_APPEND: begin
								if (full) begin
									res_q.status <= ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_DONE;
							end
							OP_GET: begin
								if (pos_ok) begin
									state_q <= S_READ;
								end else begin
									res_q.status <= ST_RANGE;
									state_q      <= S_DONE;
								end
							end
							OP_DELETE: begin
								if (pos_ok) begin
									ptr_q   <= pos_w[CW-1:0];
									state_q <= S_SCAN;
								end else begin
									res_q.status <= ST_RANGE;
									state_q      <= S_DONE;
								end
							end
							OP_SEARCH: begin
								ptr_q   <= '0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_READ: begin
					res_q.read_value <= mem_rdata;
					state_q          <= S_DONE;
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					pend_s1  <= issue;
					raddr_s1 <= ptr_q[AW-1:0];
					if (hit) begin
						res_q.found <= 1'b1;
						state_q     <= S_DONE;
					end else if (!issue && !pend_s1) begin
						if (op_q == OP_DELETE) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;
	assign count     = count_q;

endmodule

[rtl/core/sequential_list_engine_top.sv]
// Sequential list engine: an array-backed list of signed 32-bit values held in one
// synchronous memory. One transfer on the input stream carries an operation (clear,
// append, get, delete, search) and gives exactly one result transfer with a status,
// the value read, a found flag, the element count and a non-empty flag. Items are
// worked one at a time; an output register holds the finished result so the next
// item can be taken while the result still waits downstream. Search and delete stream
// through the store over its single read port, one entry per cycle, with the read
// data registered. The store needs no clearing after reset; only entries below the
// count are ever read.
module sequential_list_engine_top
	import sle_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // position[6:0], item_value[38:7], zero pad
	input  logic [OP_W-1:0]       s_tuser,   // operation[2:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], read_value[33:2], found[34],
	                                         // element_count[41:35], has_elements[42], zero pad
);

	// Address width of the store and width of the count, which must also hold
	// CAPACITY itself.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic [CW-1:0]    count;
	logic [CW+CNT_W-1:0] count_ext;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [VAL_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [VAL_W-1:0] mem_rdata;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	sle_seq #(
		.CAPACITY(CAPACITY),
		.AW      (AW),
		.CW      (CW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_pos   (s_tdata[IN_POS_LSB +: POS_W]),
		.in_val   (s_tdata[IN_VAL_LSB +: VAL_W]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.count    (count),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	sle_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// The output register takes a new result whenever it is empty or its current
	// result is leaving in this cycle. The reported count is the low seven bits of
	// the internal count.
	assign res_ready = !m_valid_q || m_tready;
	assign count_ext = {{CNT_W{1'b0}}, count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_data_q <= {
				{(OUT_DATA_W - OUT_HAS_BIT - 1){1'b0}},
				(count != '0),
				count_ext[CNT_W-1:0],
				res.found,
				res.read_value,
				res.status
			};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

[rtl/core/sle_checker.sv]
// Port-level checker of the sequential list engine and its binding to the top level.
`include "sequential_list_engine_top_assert.svh"

module sle_checker
	import sle_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// A waiting result keeps its value until it is taken.
	`SLE_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Every operation keeps the engine busy in the cycle after its acceptance.
	`SLE_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A nonzero count always comes with the non-empty flag.
	`SLE_ASSERT_IMP(a_nonempty_flag, clk, arst_n, m_tvalid && (m_tdata[OUT_CNT_LSB +: CNT_W] != '0), m_tdata[OUT_HAS_BIT])

	// A failed operation reports no data and no match.
	`SLE_ASSERT_IMP(a_error_clean, clk, arst_n, m_tvalid && (m_tdata[OUT_ST_LSB +: ST_W] != ST_OK), (m_tdata[OUT_RV_LSB +: VAL_W] == '0) && !m_tdata[OUT_FD_BIT])

endmodule

bind sequential_list_engine_top sle_checker u_sle_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

[tb/sequential_list_engine_top_test.sv]
// Self-checking testbench for the sequential list engine, with its own list predictor.
`timescale 1ns / 1ps

module sequential_list_engine_top_test;
	import sle_pkg::*;

	// The list is built with its stock depth, so full-list appends come quickly.
	localparam int DEPTH = 64;

	// The directed part comes first, then about this many random requests.
	localparam int RANDOM_ITEMS = 1400;

	// Longest walk through the store plus margin; used once all requests are in.
	localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

	// The slowest correct run needs about 1500 requests, each with a sender gap and a
	// receiver stall, plus one long hold-off; the limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 1000000;

	// After this many checked replies the receiver stops taking replies for a while.
	localparam int HOLD_AT  = 300;
	localparam int HOLD_LEN = 400;

	// Operation codes 5 to 7 are not assigned; the block must leave the list alone.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;

	// One request as the generator builds it; gap is the idle time after its transfer.
	typedef struct {
		logic [OP_W-1:0]         op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
		int                      gap;
	} list_req_t;

	// One reply as the block reports it.
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [VAL_W-1:0] read_value;
		logic             found;
		logic [CNT_W-1:0] count;
		logic             has_elements;
	} list_reply_t;

	// Shapes of the random part: build the list up to full, empty it, or mix freely.
	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} gen_mode_t;

	// Clock, reset and block ports. Every input holds a known value from time zero.
	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]       s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Requests waiting to be offered, and replies the predictor has worked out.
	list_req_t   request_queue[$];
	list_reply_t pending_replies[$];

	// Predictor state: its own copy of the stored elements and the count.
	logic signed [VAL_W-1:0] shadow_store [DEPTH];
	int                      shadow_count = 0;

	// Generator bookkeeping: a count tracker and recently appended values for searches.
	int                      gen_count = 0;
	logic signed [VAL_W-1:0] value_pool[$];
	bit                      calm = 1'b0;
	int                      directed_items = 0;

	// Run statistics and the failure tally.
	int mismatches     = 0;
	int requests_sent  = 0;
	int replies_checked = 0;
	int full_hits      = 0;
	int range_hits     = 0;
	int search_hits    = 0;

	// Driver, monitor and hold-off bookkeeping.
	list_req_t offered;
	int        gap_left   = 0;
	int        stall_left = 0;
	int        hold_left  = 0;
	bit        hold_done  = 1'b0;
	logic      holding    = 1'b0;

	sequential_list_engine_top #(
		.CAPACITY(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Applies one request to the shadow list and returns the reply it must produce.
	function automatic list_reply_t list_apply(input list_req_t req);
		list_reply_t r;
		int          k;
		r.status     = ST_OK;
		r.read_value = '0;
		r.found      = 1'b0;
		case (req.op)
			OP_CLEAR: begin
				shadow_count = 0;
			end
			OP_APPEND: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
					full_hits++;
				end else begin
					shadow_store[shadow_count] = req.value;
					shadow_count++;
				end
			end
			OP_GET: begin
				if (req.pos == 0 || int'(req.pos) > shadow_count) begin
					r.status = ST_RANGE;
					range_hits++;
				end else begin
					r.read_value = shadow_store[int'(req.pos) - 1];
				end
			end
			OP_DELETE: begin
				if (req.pos == 0 || int'(req.pos) > shadow_count) begin
					r.status = ST_RANGE;
					range_hits++;
				end else begin
					// Every element above the deleted one moves down one place.
					for (k = int'(req.pos) - 1; k + 1 < shadow_count; k++)
						shadow_store[k] = shadow_store[k + 1];
					shadow_count--;
				end
			end
			OP_SEARCH: begin
				for (k = 0; k < shadow_count; k++) begin
					if (shadow_store[k] == req.value) begin
						r.found = 1'b1;
						search_hits++;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		r.count        = shadow_count[CNT_W-1:0];
		r.has_elements = (shadow_count != 0);
		return r;
	endfunction

	// Puts a request on the queue and keeps the generator's count in step with it.
	task automatic queue_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] value);
		list_req_t req;
		req.op    = op;
		req.pos   = pos;
		req.value = value;
		req.gap   = calm ? 0 : $urandom_range(0, 4);
		request_queue.push_back(req);
		case (op)
			OP_CLEAR: begin
				gen_count = 0;
			end
			OP_APPEND: begin
				if (gen_count < DEPTH) begin
					gen_count++;
					value_pool.push_back(value);
					if (value_pool.size() > 16)
						void'(value_pool.pop_front());
				end
			end
			OP_DELETE: begin
				if (pos != 0 && int'(pos) <= gen_count)
					gen_count--;
			end
			default: begin
			end
		endcase
	endtask

	// Mostly a valid position, sometimes zero, one past the end or anything at all.
	function automatic logic [POS_W-1:0] pick_pos();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75 && gen_count > 0)
			return POS_W'($urandom_range(1, gen_count));
		else if (r < 85)
			return '0;
		else if (r < 95)
			return POS_W'(gen_count + 1);
		else
			return POS_W'($urandom_range(0, 127));
	endfunction

	// Random values with the extremes of the signed range mixed in.
	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'sh8000_0000;
		else if (r == 1)
			return 32'sh7fff_ffff;
		else if (r == 2)
			return '0;
		else if (r == 3)
			return -32'sd1;
		else
			return $urandom;
	endfunction

	// Searches mostly look for something appended lately, so hits are common.
	function automatic logic signed [VAL_W-1:0] pick_search();
		if (value_pool.size() > 0 && $urandom_range(0, 9) < 6)
			return value_pool[$urandom_range(0, value_pool.size() - 1)];
		return pick_value();
	endfunction

	// Adds one random request whose operation mix follows the phase mode.
	task automatic add_random(input gen_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				if (r < 80)      queue_req(OP_APPEND, pick_pos(), pick_value());
				else if (r < 88) queue_req(OP_GET, pick_pos(), pick_value());
				else if (r < 96) queue_req(OP_SEARCH, pick_pos(), pick_search());
				else             queue_req(OP_DELETE, pick_pos(), pick_value());
			end
			MODE_DRAIN: begin
				if (r < 55)      queue_req(OP_DELETE, pick_pos(), pick_value());
				else if (r < 70) queue_req(OP_GET, pick_pos(), pick_value());
				else if (r < 85) queue_req(OP_SEARCH, pick_pos(), pick_search());
				else if (r < 95) queue_req(OP_APPEND, pick_pos(), pick_value());
				else             queue_req(OP_SPARE_LO + OP_W'($urandom_range(0, 2)),
						pick_pos(), pick_value());
			end
			default: begin
				if (r < 30)      queue_req(OP_APPEND, pick_pos(), pick_value());
				else if (r < 50) queue_req(OP_GET, pick_pos(), pick_value());
				else if (r < 70) queue_req(OP_DELETE, pick_pos(), pick_value());
				else if (r < 88) queue_req(OP_SEARCH, pick_pos(), pick_search());
				else if (r < 92) queue_req(OP_CLEAR, pick_pos(), pick_value());
				else             queue_req(OP_SPARE_LO + OP_W'($urandom_range(0, 2)),
						POS_W'($urandom_range(0, 127)), pick_value());
			end
		endcase
	endtask

	// Reports one field of a reply that differs from the prediction.
	task automatic check_field(input string what, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] seen);
		if (want !== seen) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, seen);
			mismatches++;
		end
	endtask

	// Driver. When the offered request has made its transfer, the predictor works out
	// its reply at once; then the driver idles for the drawn gap or offers the next one.
	// tvalid gets at most one assignment per edge, so a back-to-back request never
	// sees tvalid dip.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				pending_replies.push_back(list_apply(offered));
				requests_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_queue.size() > 0) begin
				offered  = request_queue.pop_front();
				gap_left = offered.gap;
				s_tvalid <= 1'b1;
				// Bit 39 of tdata is padding and stays zero.
				s_tdata  <= {1'b0, offered.value, offered.pos};
				s_tuser  <= offered.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor. Each reply transfer is unpacked and compared field by field with the
	// oldest prediction; after each one the receiver draws a short stall, except in
	// every third stretch of a hundred replies, where it takes replies back to back.
	always @(posedge clk or negedge arst_n) begin
		list_reply_t got;
		list_reply_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status       = m_tdata[OUT_ST_LSB +: ST_W];
				got.read_value   = m_tdata[OUT_RV_LSB +: VAL_W];
				got.found        = m_tdata[OUT_FD_BIT];
				got.count        = m_tdata[OUT_CNT_LSB +: CNT_W];
				got.has_elements = m_tdata[OUT_HAS_BIT];
				if (pending_replies.size() == 0) begin
					$display("%0t ns: reply mismatch, expected no reply, got 0x%0h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = pending_replies.pop_front();
					check_field("status", VAL_W'(want.status), VAL_W'(got.status));
					check_field("read_value", want.read_value, got.read_value);
					check_field("found", VAL_W'(want.found), VAL_W'(got.found));
					check_field("element_count", VAL_W'(want.count), VAL_W'(got.count));
					check_field("has_elements", VAL_W'(want.has_elements),
						VAL_W'(got.has_elements));
				end
				replies_checked <= replies_checked + 1;
				stall_left = ((replies_checked / 100) % 3 == 2) ? 0 : $urandom_range(0, 4);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			m_tready <= (stall_left == 0) && !holding;
		end
	end

	// Long hold-off, counted here in cycles. While it lasts the sender keeps offering,
	// so the result register and the working item fill up and s_tready must drop.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding <= 1'b0;
		end else begin
			if (!hold_done && replies_checked == HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			holding <= (hold_left > 0);
		end
	end

	// Timeout watchdog.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d replies outstanding",
			cycles, pending_replies.size());
		$display("FAIL sequential_list_engine_top");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		int        phase;
		gen_mode_t mode;

		// Directed part: empty-list errors, signed extremes, the edges of the position
		// range, a hit and a miss, deletes at both ends, unused codes and a clear.
		queue_req(OP_CLEAR, 7'd0, 32'sd0);
		queue_req(OP_GET, 7'd1, 32'sd0);
		queue_req(OP_DELETE, 7'd1, 32'sd0);
		queue_req(OP_SEARCH, 7'd0, 32'sd0);
		queue_req(OP_APPEND, 7'd0, 32'sh8000_0000);
		queue_req(OP_APPEND, 7'd127, 32'sh7fff_ffff);
		queue_req(OP_APPEND, 7'd0, 32'sd0);
		queue_req(OP_APPEND, 7'd0, -32'sd1);
		queue_req(OP_GET, 7'd1, 32'sd0);
		queue_req(OP_GET, 7'd4, 32'sd0);
		queue_req(OP_GET, 7'd0, 32'sd0);
		queue_req(OP_GET, 7'd5, 32'sd0);
		queue_req(OP_GET, 7'd127, -32'sd1);
		queue_req(OP_SEARCH, 7'd0, 32'sh7fff_ffff);
		queue_req(OP_SEARCH, 7'd0, 32'sd12345);
		queue_req(OP_DELETE, 7'd4, 32'sd0);
		queue_req(OP_DELETE, 7'd1, 32'sd0);
		queue_req(OP_GET, 7'd1, 32'sd0);
		queue_req(OP_DELETE, 7'd0, 32'sd0);
		queue_req(OP_DELETE, 7'd127, 32'sd0);
		queue_req(OP_SPARE_LO, 7'd1, 32'sh7fff_ffff);
		queue_req(OP_SPARE_LO + 3'd1, 7'd127, 32'sh8000_0000);
		queue_req(OP_SPARE_LO + 3'd2, 7'd2, -32'sd1);
		queue_req(OP_CLEAR, 7'd127, -32'sd1);
		queue_req(OP_GET, 7'd1, 32'sd0);
		directed_items = request_queue.size();

		// Random part in phases. Filling runs the list up to its capacity and then
		// tries a few more appends; draining runs it back to empty; mixing is free.
		while (request_queue.size() < directed_items + RANDOM_ITEMS) begin
			phase = $urandom_range(0, 2);
			mode  = (phase == 0) ? MODE_FILL : (phase == 1) ? MODE_DRAIN : MODE_MIX;
			calm  = ($urandom_range(0, 3) == 0);
			case (mode)
				MODE_FILL: begin
					while (gen_count < DEPTH)
						add_random(MODE_FILL);
					repeat ($urandom_range(1, 4))
						queue_req(OP_APPEND, pick_pos(), pick_value());
				end
				MODE_DRAIN: begin
					while (gen_count > 0)
						add_random(MODE_DRAIN);
				end
				default: begin
					repeat (40)
						add_random(MODE_MIX);
				end
			endcase
		end
		calm = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to be taken and every reply to come back, then give
		// the block time to show any reply it should not produce.
		while (request_queue.size() != 0 || s_tvalid || pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d directed) and %0d checked replies.",
			requests_sent, directed_items, replies_checked);
		$display("Seen: %0d appends to a full list, %0d bad positions, %0d search hits.",
			full_hits, range_hits, search_hits);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("PASS sequential_list_engine_top");
		end else begin
			$display("FAIL sequential_list_engine_top");
		end
		$finish;
	end

endmodule
